@@ src/erp_pkg.sv @@
// Shared types, constants and tables of the Euler-angle point transform.
package erp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int ATAN_COUNT = 24;
  localparam int ITER_W     = 5;
  localparam int CX_W       = 34;
  localparam int CZ_W       = 32;
  localparam int ANG_W      = 17;
  localparam int ANGLE_SHIFT = 15;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [ANG_W-1:0] FULL_TURN    = 17'sd46080;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [CZ_W-1:0] ATAN_DEG22 [ATAN_COUNT] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485, 32'sd15000234,
    32'sd7507429, 32'sd3754631, 32'sd1877430, 32'sd938729, 32'sd469367,
    32'sd234683, 32'sd117342, 32'sd58671, 32'sd29335, 32'sd14668,
    32'sd7334, 32'sd3667, 32'sd1833, 32'sd917, 32'sd458,
    32'sd229, 32'sd115, 32'sd57, 32'sd29
  };

  localparam logic KIND_ANGLES = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] rotated_x;
    logic signed [23:0] rotated_y;
    logic signed [23:0] rotated_z;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

endpackage

@@ src/erp_cordic.sv @@
// Iterative rotation-mode CORDIC giving sine and cosine of one angle.
module erp_cordic #(
  parameter int CORDIC_STEPS = erp_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = erp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [15:0]          angle_i,
  output logic                        done_o,
  output logic signed [FRAC_BITS+1:0] sin_o,
  output logic signed [FRAC_BITS+1:0] cos_o
);

  localparam int EW  = FRAC_BITS + 2;
  localparam int NIT = (CORDIC_STEPS > erp_pkg::ATAN_COUNT) ? erp_pkg::ATAN_COUNT
                                                             : CORDIC_STEPS;
  localparam int XW  = erp_pkg::CX_W;
  localparam int ZW  = erp_pkg::CZ_W;
  localparam int AW  = erp_pkg::ANG_W;

  logic                       busy_q;
  logic                       done_q;
  logic                       flip_q;
  logic [erp_pkg::ITER_W-1:0] i_q;
  logic signed [XW-1:0]       x_q, y_q;
  logic signed [ZW-1:0]       z_q;
  logic signed [EW-1:0]       sin_q, cos_q;

  logic signed [AW-1:0] a_wrap, a_red;
  logic                 flip_d;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] atan_v;
  logic                 last;

  function automatic logic signed [EW-1:0] to_frac(logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    logic signed [XW-1:0] one;
    one = XW'(1) <<< FRAC_BITS;
    r   = (v + (XW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return EW'(r);
  endfunction

  always_comb begin
    a_wrap = AW'(angle_i);
    if (a_wrap > erp_pkg::HALF_TURN) begin
      a_wrap = a_wrap - erp_pkg::FULL_TURN;
    end else if (a_wrap < -erp_pkg::HALF_TURN) begin
      a_wrap = a_wrap + erp_pkg::FULL_TURN;
    end
    a_red  = a_wrap;
    flip_d = 1'b0;
    if (a_wrap > erp_pkg::QUARTER_TURN) begin
      a_red  = a_wrap - erp_pkg::HALF_TURN;
      flip_d = 1'b1;
    end else if (a_wrap < -erp_pkg::QUARTER_TURN) begin
      a_red  = a_wrap + erp_pkg::HALF_TURN;
      flip_d = 1'b1;
    end
  end

  assign last   = (i_q == erp_pkg::ITER_W'(NIT));
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign atan_v = last ? '0 : erp_pkg::ATAN_DEG22[i_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= erp_pkg::CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= ZW'(a_red) <<< erp_pkg::ANGLE_SHIFT;
      flip_q <= flip_d;
    end else if (busy_q && !last) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end
    end else if (busy_q && last) begin
      cos_q <= flip_q ? -to_frac(x_q) : to_frac(x_q);
      sin_q <= flip_q ? -to_frac(y_q) : to_frac(y_q);
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

@@ src/erp_mac.sv @@
// Shared multiplier with registered product and accumulator.
module erp_mac #(
  parameter int A_W = 18,
  parameter int B_W = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  erp_pkg::mac_ctl_t          ctl_i,
  input  logic signed [A_W-1:0]      a_i,
  input  logic signed [B_W-1:0]      b_i,
  output logic signed [A_W+B_W+1:0]  acc_o
);

  localparam int PW   = A_W + B_W;
  localparam int ACCW = PW + 2;

  logic signed [PW-1:0]   prod_q;
  logic signed [ACCW-1:0] acc_q;
  logic                   prod_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    if (ctl_i.acc_load) begin
      acc_q <= ACCW'(prod_q);
    end else if (ctl_i.acc_add) begin
      acc_q <= acc_q + ACCW'(prod_q);
    end
  end

  assign acc_o = acc_q;

  property p_acc_uses_fresh_product;
    @(posedge clk_i) disable iff (!rst_ni)
      (ctl_i.acc_load || ctl_i.acc_add) |-> prod_vld_q;
  endproperty
  a_acc_uses_fresh_product: assert property (p_acc_uses_fresh_product)
    else $error("accumulate without a product issued the cycle before");

  property p_load_add_exclusive;
    @(posedge clk_i) disable iff (!rst_ni)
      ctl_i.acc_load |-> !ctl_i.acc_add;
  endproperty
  a_load_add_exclusive: assert property (p_load_add_exclusive)
    else $error("accumulator load and add together");

  property p_add_follows_load;
    @(posedge clk_i) disable iff (!rst_ni)
      ctl_i.acc_load |=> ctl_i.acc_add;
  endproperty
  a_add_follows_load: assert property (p_add_follows_load)
    else $error("dot product cut short after load");

endmodule

@@ src/euler_rotation_point_transform.sv @@
// Top level: sequencer, matrix store and point rotation of the Euler transform.
//
// An angle transfer (kind 0) runs three CORDIC passes, then builds
// R = Rx*(Ry*Rz) as two 3x3 products of 9 entries, each entry a dot product on
// the one shared multiplier, and it gives no result. A point transfer (kind 1)
// takes three dot products on the same multiplier until its result sits in the
// output register. One item is worked at a time; input is taken again once the
// sequencer is idle, even while a result still waits.
// The stored matrix resets to identity.
module euler_rotation_point_transform #(
  parameter int CORDIC_STEPS = erp_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = erp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  erp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output erp_pkg::out_item_t out_data_o
);

  localparam int EW   = FRAC_BITS + 2;
  localparam int BW   = (EW > 24) ? EW : 24;
  localparam int ACCW = EW + BW + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CSTART = 3'd1;
  localparam logic [2:0] S_CWAIT  = 3'd2;
  localparam logic [2:0] S_MUL1   = 3'd3;
  localparam logic [2:0] S_MUL2   = 3'd4;
  localparam logic [2:0] S_PT     = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [2:0] PH_LAST = 3'd4;

  localparam logic signed [EW-1:0]   ONE_E   = EW'(1) <<< FRAC_BITS;
  localparam logic signed [ACCW-1:0] ONE_A   = ACCW'(1) <<< FRAC_BITS;
  localparam logic signed [ACCW-1:0] HALF_A  = ACCW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACCW-1:0] PT_MAX  = ACCW'(8388607);
  localparam logic signed [ACCW-1:0] PT_MIN  = -ACCW'(8388608);

  logic [2:0] state_q, state_d;
  logic [1:0] csel_q, csel_d;
  logic [2:0] ph_q, ph_d;
  logic [1:0] r_q, r_d;
  logic [1:0] k_q, k_d;
  logic       out_valid_q, out_valid_d;

  logic signed [15:0]   ang_q [3];
  logic signed [23:0]   pt_q  [3];
  logic signed [EW-1:0] sin_q [3];
  logic signed [EW-1:0] cos_q [3];
  logic signed [EW-1:0] tmp_q [9];
  logic signed [EW-1:0] rot_q [9];
  logic signed [23:0]   res_q [3];
  logic                 sat_q;
  erp_pkg::out_item_t   out_q;

  logic                 accept;
  logic                 cord_start, cord_done;
  logic signed [15:0]   cord_angle;
  logic signed [EW-1:0] cord_sin, cord_cos;

  logic signed [EW-1:0] rx_m [9];
  logic signed [EW-1:0] ry_m [9];
  logic signed [EW-1:0] rz_m [9];

  logic [3:0]             e_rj, e_jk, e_rk;
  logic [1:0]             j_idx;
  logic signed [EW-1:0]   op_a;
  logic signed [BW-1:0]   op_b;
  erp_pkg::mac_ctl_t      mac_ctl;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] rnd;
  logic signed [EW-1:0]   mat_val;
  logic signed [23:0]     pt_val;
  logic                   pt_sat;
  logic                   in_mul, fin, last_e;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    unique case (csel_q)
      2'd0:    cord_angle = ang_q[0];
      2'd1:    cord_angle = ang_q[1];
      default: cord_angle = ang_q[2];
    endcase
  end

  assign cord_start = (state_q == S_CSTART);

  erp_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .angle_i(cord_angle),
    .done_o (cord_done),
    .sin_o  (cord_sin),
    .cos_o  (cord_cos)
  );

  assign rx_m = '{ONE_E, '0, '0, '0, cos_q[0], -sin_q[0], '0, sin_q[0], cos_q[0]};
  assign ry_m = '{cos_q[1], '0, sin_q[1], '0, ONE_E, '0, -sin_q[1], '0, cos_q[1]};
  assign rz_m = '{cos_q[2], -sin_q[2], '0, sin_q[2], cos_q[2], '0, '0, '0, ONE_E};

  assign j_idx = ph_q[1:0];
  assign e_rj  = 4'({r_q, 1'b0}) + 4'(r_q) + 4'(j_idx);
  assign e_jk  = 4'({j_idx, 1'b0}) + 4'(j_idx) + 4'(k_q);
  assign e_rk  = 4'({r_q, 1'b0}) + 4'(r_q) + 4'(k_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (e_rj < 4'd9 && e_jk < 4'd9 && j_idx != 2'd3) begin
      unique case (state_q)
        S_MUL1: begin
          op_a = ry_m[e_rj];
          op_b = BW'(rz_m[e_jk]);
        end
        S_MUL2: begin
          op_a = rx_m[e_rj];
          op_b = BW'(tmp_q[e_jk]);
        end
        S_PT: begin
          op_a = rot_q[e_rj];
          op_b = BW'(pt_q[j_idx]);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  assign in_mul           = (state_q == S_MUL1) || (state_q == S_MUL2) || (state_q == S_PT);
  assign mac_ctl.mul_en   = in_mul && (ph_q < 3'd3);
  assign mac_ctl.acc_load = in_mul && (ph_q == 3'd1);
  assign mac_ctl.acc_add  = in_mul && ((ph_q == 3'd2) || (ph_q == 3'd3));

  erp_mac #(
    .A_W(EW),
    .B_W(BW)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .a_i   (op_a),
    .b_i   (op_b),
    .acc_o (acc)
  );

  always_comb begin
    rnd = (acc + HALF_A) >>> FRAC_BITS;
    if (rnd > ONE_A) begin
      mat_val = ONE_E;
    end else if (rnd < -ONE_A) begin
      mat_val = -ONE_E;
    end else begin
      mat_val = EW'(rnd);
    end
    pt_sat = 1'b1;
    if (rnd > PT_MAX) begin
      pt_val = 24'sh7FFFFF;
    end else if (rnd < PT_MIN) begin
      pt_val = 24'sh800000;
    end else begin
      pt_val = 24'(rnd);
      pt_sat = 1'b0;
    end
  end

  assign fin    = in_mul && (ph_q == PH_LAST);
  assign last_e = (state_q == S_PT) ? (r_q == 2'd2) : (r_q == 2'd2 && k_q == 2'd2);

  always_comb begin
    state_d     = state_q;
    csel_d      = csel_q;
    ph_d        = ph_q;
    r_d         = r_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ph_d = '0;
          r_d  = '0;
          k_d  = '0;
          csel_d = '0;
          state_d = (in_data_i.kind == erp_pkg::KIND_POINT) ? S_PT : S_CSTART;
        end
      end
      S_CSTART: state_d = S_CWAIT;
      S_CWAIT: begin
        if (cord_done) begin
          if (csel_q == 2'd2) begin
            state_d = S_MUL1;
          end else begin
            csel_d  = csel_q + 1'b1;
            state_d = S_CSTART;
          end
        end
      end
      S_MUL1, S_MUL2, S_PT: begin
        if (ph_q == PH_LAST) begin
          ph_d = '0;
          if (last_e) begin
            r_d = '0;
            k_d = '0;
            priority case (state_q)
              S_MUL1:  state_d = S_MUL2;
              S_MUL2:  state_d = S_IDLE;
              default: state_d = S_OUT;
            endcase
          end else if (state_q == S_PT || k_q == 2'd2) begin
            k_d = '0;
            r_d = r_q + 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      csel_q      <= '0;
      ph_q        <= '0;
      r_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        rot_q[i] <= (i % 4 == 0) ? ONE_E : '0;
      end
    end else begin
      state_q     <= state_d;
      csel_q      <= csel_d;
      ph_q        <= ph_d;
      r_q         <= r_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (fin && state_q == S_MUL2) begin
        rot_q[e_rk] <= mat_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ang_q[0] <= in_data_i.roll_angle;
      ang_q[1] <= in_data_i.pitch_angle;
      ang_q[2] <= in_data_i.yaw_angle;
      pt_q[0]  <= in_data_i.point_x;
      pt_q[1]  <= in_data_i.point_y;
      pt_q[2]  <= in_data_i.point_z;
      sat_q    <= 1'b0;
    end
    if (state_q == S_CWAIT && cord_done) begin
      sin_q[csel_q] <= cord_sin;
      cos_q[csel_q] <= cord_cos;
    end
    if (fin && state_q == S_MUL1) begin
      tmp_q[e_rk] <= mat_val;
    end
    if (fin && state_q == S_PT) begin
      res_q[r_q] <= pt_val;
      if (pt_sat) begin
        sat_q <= 1'b1;
      end
    end
    if (state_q == S_OUT && !(out_valid_q && out_stall_i)) begin
      out_q.rotated_x <= res_q[0];
      out_q.rotated_y <= res_q[1];
      out_q.rotated_z <= res_q[2];
      out_q.saturated <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  property p_phase_range;
    @(posedge clk_i) disable iff (!rst_ni) ph_q <= PH_LAST;
  endproperty
  a_phase_range: assert property (p_phase_range)
    else $error("dot product phase out of range");

  property p_point_single_column;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_PT) |-> (k_q == 2'd0);
  endproperty
  a_point_single_column: assert property (p_point_single_column)
    else $error("point rotation stepped a column index");

  property p_angle_starts_cordic;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && in_data_i.kind == erp_pkg::KIND_ANGLES) |=>
        (state_q == S_CSTART && csel_q == 2'd0);
  endproperty
  a_angle_starts_cordic: assert property (p_angle_starts_cordic)
    else $error("angle transfer did not start the CORDIC");

  property p_result_issued;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_OUT && !(out_valid_q && out_stall_i)) |=>
        (out_valid_q && state_q == S_IDLE);
  endproperty
  a_result_issued: assert property (p_result_issued)
    else $error("finished point not placed in output register");

  property p_cordic_done_waited;
    @(posedge clk_i) disable iff (!rst_ni) cord_done |-> (state_q == S_CWAIT);
  endproperty
  a_cordic_done_waited: assert property (p_cordic_done_waited)
    else $error("CORDIC finished outside its wait state");

endmodule
